FILE: src/tap_pkg.sv
// Shared constants and types for the tensor axis permute block.
`default_nettype none
package tap_pkg;

	localparam int REG_AXES   = 4;
	localparam int DIM_BITS   = 13;
	localparam int ORDER_BITS = 8;
	localparam int FIELD_BITS = 2;
	localparam int IDX_BITS   = 3;
	localparam int DATA_BITS  = 32;

	// Register indexes: dim_size_0..3 sit below REG_AXIS_ORDER
	localparam logic [IDX_BITS-1:0] REG_DIM_SIZE_0 = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_AXIS_ORDER = 3'd4;

	localparam logic [DIM_BITS-1:0]   DIM_RESET   = 13'd1;
	localparam logic [ORDER_BITS-1:0] ORDER_RESET = 8'd228;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	typedef enum logic {
		ST_CALC,
		ST_RUN
	} seq_state_t;

endpackage
`default_nettype wire

FILE: src/tap_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tap_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/tensor_axis_permute.sv
// Top level of the tensor axis permute block: config, stride sequencer, store and emit path.
//
//   channel | direction | handshake             | payload
//   cfg     | in        | cfg_we                | cfg_index, cfg_data
//   in      | in        | in_valid / in_stall   | opcode, elem_data
//   out     | out       | out_valid / out_stall | out_data, last_of_tensor, config_error
//
// One item per cycle is accepted while in_stall is low; an emit result passes through the
// store read stage and then the output register before it shows on out.
// After reset and after every config write to a register, a stride pass runs with one
// multiply per axis, with in_stall high; config writes are still taken during it.
// The store read stage and the output register form a two-entry queue; in_stall rises when
// both hold a result and out_stall is high, and throughout the stride pass.
`default_nettype none
module tensor_axis_permute #(
	parameter int AXES      = 4,
	parameter int MAX_ELEMS = 4096,
	parameter int ELEM_BITS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tap_pkg::IDX_BITS-1:0]   cfg_index,
	input  wire logic [tap_pkg::DIM_BITS-1:0]   cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           opcode,
	input  wire logic [tap_pkg::DATA_BITS-1:0]  elem_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [tap_pkg::DATA_BITS-1:0]  out_data,
	output logic                                last_of_tensor,
	output logic                                config_error
);

	import tap_pkg::*;

	localparam int NA = (AXES < REG_AXES) ? AXES : REG_AXES;
	localparam int SW = (NA > 1) ? $clog2(NA) : 1;
	localparam int AW = $clog2(MAX_ELEMS);
	localparam int CW = $clog2(MAX_ELEMS + 1);
	localparam int PW = CW + DIM_BITS;

	// Configuration registers
	logic [DIM_BITS-1:0]   dim_q [REG_AXES];
	logic [ORDER_BITS-1:0] axis_q;
	logic                  cfg_hit;

	assign cfg_hit = cfg_we && (cfg_index <= REG_AXIS_ORDER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < REG_AXES; k++) begin
				dim_q[k] <= DIM_RESET;
			end
			axis_q <= ORDER_RESET;
		end else if (cfg_we) begin
			if (cfg_index < REG_AXIS_ORDER) begin
				dim_q[cfg_index[FIELD_BITS-1:0]] <= cfg_data;
			end else if (cfg_index == REG_AXIS_ORDER) begin
				axis_q <= cfg_data[ORDER_BITS-1:0];
			end
		end
	end

	logic [FIELD_BITS-1:0] perm [REG_AXES];
	logic                  perm_bad;
	logic                  zero_dim;

	always_comb begin
		perm_bad = 1'b0;
		zero_dim = 1'b0;
		for (int k = 0; k < REG_AXES; k++) begin
			perm[k] = axis_q[FIELD_BITS*k +: FIELD_BITS];
		end
		for (int k = 0; k < NA; k++) begin
			if (int'(perm[k]) >= NA) begin
				perm_bad = 1'b1;
			end
			for (int m = 0; m < NA; m++) begin
				if ((m < k) && (perm[m] == perm[k])) begin
					perm_bad = 1'b1;
				end
			end
			if (dim_q[k] == '0) begin
				zero_dim = 1'b1;
			end
		end
	end

	// Stride sequencer: walk axes innermost first, one multiply a cycle
	seq_state_t        state_q, state_d;
	logic [SW-1:0]     step_q;
	logic [CW-1:0]     run_q;
	logic              ovf_q;
	logic              err_q;
	logic [CW-1:0]     stride_q [REG_AXES];
	logic [PW-1:0]     prod;
	logic              ovf_n;

	assign prod  = PW'(run_q) * PW'(dim_q[step_q]);
	assign ovf_n = ovf_q || (prod > PW'(MAX_ELEMS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CALC;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CALC: begin
				if (cfg_hit) begin
					state_d = ST_CALC;
				end else if (step_q == '0) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cfg_hit) begin
					state_d = ST_CALC;
				end
			end
			default: state_d = ST_CALC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= SW'(NA - 1);
			run_q  <= CW'(1);
			ovf_q  <= 1'b0;
			err_q  <= 1'b1;
		end else if (cfg_hit) begin
			step_q <= SW'(NA - 1);
			run_q  <= CW'(1);
			ovf_q  <= 1'b0;
		end else if (state_q == ST_CALC) begin
			ovf_q <= ovf_n;
			// hold the product once it has passed capacity
			if (!ovf_n) begin
				run_q <= prod[CW-1:0];
			end
			if (step_q == '0) begin
				err_q <= ovf_n || perm_bad || zero_dim;
			end else begin
				step_q <= step_q - SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_CALC) && !cfg_hit) begin
			stride_q[step_q] <= run_q;
		end
	end

	// Load and emit counters
	logic [AW-1:0]       load_q;
	logic [DIM_BITS-1:0] crd_q [NA];
	logic [AW-1:0]       off_q [NA];
	logic [DIM_BITS-1:0] crd_d [NA];
	logic [AW-1:0]       off_d [NA];
	logic                last_d;
	logic [AW-1:0]       rd_addr;
	logic                crd_any;
	logic [CW:0]         ld_sum;
	logic                ld_wrap;

	logic accept, do_load, do_emit, ram_re;
	logic emit_v_s1, err_s1, last_s1;
	logic adv;
	logic out_v_q, out_last_q, out_err_q;
	logic [DATA_BITS-1:0] out_data_q;
	logic [ELEM_BITS-1:0] rdata;

	assign in_stall = (state_q != ST_RUN) || (emit_v_s1 && out_v_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign do_load  = accept && (opcode == OP_LOAD) && !err_q;
	assign do_emit  = accept && (opcode == OP_EMIT);
	assign ram_re   = do_emit && !err_q;

	assign ld_sum  = (CW+1)'(load_q) + (CW+1)'(1);
	assign ld_wrap = ld_sum >= (CW+1)'(run_q);

	always_comb begin
		logic carry;
		carry   = 1'b1;
		rd_addr = '0;
		crd_any = 1'b0;
		for (int k = 0; k < NA; k++) begin
			rd_addr = rd_addr + off_q[k];
			crd_any = crd_any | (crd_q[k] != '0);
			crd_d[k] = crd_q[k];
			off_d[k] = off_q[k];
		end
		// advance the innermost output axis, ripple the wrap outward
		for (int k = NA - 1; k >= 0; k--) begin
			if (carry) begin
				if ((DIM_BITS+1)'(crd_q[k]) + (DIM_BITS+1)'(1) >=
				    (DIM_BITS+1)'(dim_q[perm[k]])) begin
					crd_d[k] = '0;
					off_d[k] = '0;
				end else begin
					crd_d[k] = crd_q[k] + DIM_BITS'(1);
					off_d[k] = off_q[k] + AW'(stride_q[perm[k]]);
					carry    = 1'b0;
				end
			end
		end
		last_d = carry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
			for (int k = 0; k < NA; k++) begin
				crd_q[k] <= '0;
				off_q[k] <= '0;
			end
		end else if (cfg_hit) begin
			load_q <= '0;
			for (int k = 0; k < NA; k++) begin
				crd_q[k] <= '0;
				off_q[k] <= '0;
			end
		end else begin
			if (do_load) begin
				load_q <= ld_wrap ? '0 : ld_sum[AW-1:0];
			end
			if (ram_re) begin
				for (int k = 0; k < NA; k++) begin
					crd_q[k] <= crd_d[k];
					off_q[k] <= off_d[k];
				end
			end
		end
	end

	tap_ram #(
		.WIDTH (ELEM_BITS),
		.DEPTH (MAX_ELEMS)
	) u_store (
		.clk   (clk),
		.we    (do_load),
		.waddr (load_q),
		.wdata (ELEM_BITS'(elem_data)),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// Read stage and output register
	assign adv = emit_v_s1 && (!out_v_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_v_s1 <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (do_emit) begin
				emit_v_s1 <= 1'b1;
			end else if (adv) begin
				emit_v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			err_s1  <= err_q;
			last_s1 <= last_d && !err_q;
		end
		if (adv) begin
			out_data_q <= err_s1 ? '0 : DATA_BITS'(rdata);
			out_last_q <= last_s1;
			out_err_q  <= err_s1;
		end
	end

	assign out_valid      = out_v_q;
	assign out_data       = out_data_q;
	assign last_of_tensor = out_last_q;
	assign config_error   = out_err_q;

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (!emit_v_s1 || !out_v_q || !out_stall))
		else $error("store read issued while read stage is blocked");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (CW'(rd_addr) < run_q))
		else $error("store read address beyond element count");

	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && !err_q) |-> (CW'(load_q) < run_q))
		else $error("load position beyond element count");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_re && last_d) |=> !crd_any)
		else $error("emit coordinates did not wrap after last element");

endmodule
`default_nettype wire
